/* hdl/sdasc_pkg.sv */
package sdasc_pkg;

    localparam int NUM_DIGITS = 16;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = 64;
    localparam int LEN_W      = 5;
    localparam int REQ_W      = 2;
    localparam int ORDER_W    = 2;

    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUB = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CMP = 2'd2;

    localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

endpackage

/* hdl/sdasc_req_if.sv */
interface sdasc_req_if import sdasc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [BCD_W-1:0] a_bcd;
    logic             a_neg;
    logic [BCD_W-1:0] b_bcd;
    logic             b_neg;

    modport source (
        output valid,
        output req_type,
        output a_bcd,
        output a_neg,
        output b_bcd,
        output b_neg,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  a_bcd,
        input  a_neg,
        input  b_bcd,
        input  b_neg,
        output ready
    );

endinterface

/* hdl/sdasc_rsp_if.sv */
interface sdasc_rsp_if import sdasc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [BCD_W-1:0]   result_bcd;
    logic               result_neg;
    logic [LEN_W-1:0]   result_length;
    logic               overflow;
    logic [ORDER_W-1:0] order;

    modport source (
        output valid,
        output result_bcd,
        output result_neg,
        output result_length,
        output overflow,
        output order,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_bcd,
        input  result_neg,
        input  result_length,
        input  overflow,
        input  order,
        output ready
    );

endinterface

/* hdl/signed_decimal_add_sub_compare.sv */
// An accepted request passes through the input register, then the result register, before its result is valid.
// Throughput: one request per cycle while rsp is not stalled; the carry/borrow chains are single 17-bit adds.
// Backpressure on rsp holds the result register, then the input register.
// Reset (rst_n, async, active low) clears both valid flags; the datapath needs no reset.
module signed_decimal_add_sub_compare import sdasc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sdasc_req_if.sink    req,
    sdasc_rsp_if.source  rsp
);

    localparam int ND = NUM_DIGITS;

    // returns {carry_out, sum}
    function automatic logic [BCD_W:0] bcd_add(input logic [BCD_W-1:0] x,
                                               input logic [BCD_W-1:0] y);
        logic [ND-1:0]          g;
        logic [ND-1:0]          gp;
        logic [ND:0]            chain;
        logic [ND:0]            c;
        logic [DIGIT_W:0]       s;
        logic [BCD_W-1:0]       r;
        for (int i = 0; i < ND; i++)
        begin
            s     = {1'b0, x[DIGIT_W*i +: DIGIT_W]} + {1'b0, y[DIGIT_W*i +: DIGIT_W]};
            g[i]  = (s >= 5'd10);
            gp[i] = (s >= 5'd9);
        end
        chain = {1'b0, g} + {1'b0, gp};
        c     = chain ^ {1'b0, g} ^ {1'b0, gp};
        r     = '0;
        for (int i = 0; i < ND; i++)
        begin
            s = {1'b0, x[DIGIT_W*i +: DIGIT_W]} + {1'b0, y[DIGIT_W*i +: DIGIT_W]}
              + {{DIGIT_W{1'b0}}, c[i]};
            if (s >= 5'd10)
            begin
                s = s - 5'd10;
            end
            r[DIGIT_W*i +: DIGIT_W] = s[DIGIT_W-1:0];
        end
        return {c[ND], r};
    endfunction

    // returns {borrow_out, x - y}
    function automatic logic [BCD_W:0] bcd_sub(input logic [BCD_W-1:0] x,
                                               input logic [BCD_W-1:0] y);
        logic [ND-1:0]          g;
        logic [ND-1:0]          gp;
        logic [ND:0]            chain;
        logic [ND:0]            bw;
        logic [DIGIT_W:0]       t;
        logic [BCD_W-1:0]       r;
        for (int i = 0; i < ND; i++)
        begin
            g[i]  = (x[DIGIT_W*i +: DIGIT_W] <  y[DIGIT_W*i +: DIGIT_W]);
            gp[i] = (x[DIGIT_W*i +: DIGIT_W] <= y[DIGIT_W*i +: DIGIT_W]);
        end
        chain = {1'b0, g} + {1'b0, gp};
        bw    = chain ^ {1'b0, g} ^ {1'b0, gp};
        r     = '0;
        for (int i = 0; i < ND; i++)
        begin
            t = {1'b0, x[DIGIT_W*i +: DIGIT_W]} - {1'b0, y[DIGIT_W*i +: DIGIT_W]}
              - {{DIGIT_W{1'b0}}, bw[i]};
            if (t[DIGIT_W])
            begin
                t = t + 5'd10;
            end
            r[DIGIT_W*i +: DIGIT_W] = t[DIGIT_W-1:0];
        end
        return {bw[ND], r};
    endfunction

    function automatic logic [BCD_W-1:0] clean(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = '0;
        for (int i = 0; i < ND; i++)
        begin
            r[DIGIT_W*i +: DIGIT_W] = (v[DIGIT_W*i +: DIGIT_W] > 4'd9) ? 4'd9
                                    : v[DIGIT_W*i +: DIGIT_W];
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] digit_len(input logic [BCD_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = LEN_W'(1);
        for (int i = 0; i < ND; i++)
        begin
            if (v[DIGIT_W*i +: DIGIT_W] != '0)
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    // input register
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [REQ_W-1:0] s1_type_reg;
    logic [BCD_W-1:0] s1_a_reg;
    logic             s1_an_reg;
    logic [BCD_W-1:0] s1_b_reg;
    logic             s1_bn_reg;

    // result register
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic [BCD_W-1:0]   s2_bcd_reg;
    logic [BCD_W-1:0]   s2_bcd_next;
    logic               s2_neg_reg;
    logic               s2_neg_next;
    logic [LEN_W-1:0]   s2_len_reg;
    logic [LEN_W-1:0]   s2_len_next;
    logic               s2_ovf_reg;
    logic               s2_ovf_next;
    logic [ORDER_W-1:0] s2_order_reg;
    logic [ORDER_W-1:0] s2_order_next;

    logic s2_load;
    logic s1_load;

    logic [BCD_W-1:0] ma;
    logic [BCD_W-1:0] mb;
    logic             na;
    logic             nb;
    logic             eb;
    logic [BCD_W:0]   sum_w;
    logic [BCD_W:0]   ab_w;
    logic [BCD_W:0]   ba_w;
    logic             mag_eq;
    logic             mag_gt;
    logic [BCD_W-1:0] res;
    logic             rneg;

    assign s2_load   = !s2_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s2_load;
    assign s1_load   = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req.ready)
        begin
            s1_valid_next = req.valid;
        end
    end

    assign ma     = clean(s1_a_reg);
    assign mb     = clean(s1_b_reg);
    assign na     = s1_an_reg && (ma != '0);
    assign nb     = s1_bn_reg && (mb != '0);
    assign sum_w  = bcd_add(ma, mb);
    assign ab_w   = bcd_sub(ma, mb);
    assign ba_w   = bcd_sub(mb, ma);
    assign mag_eq = (ma == mb);
    assign mag_gt = ba_w[BCD_W];

    always_comb
    begin
        if (na != nb)
        begin
            s2_order_next = na ? ORDER_LESS : ORDER_GREATER;
        end
        else if (mag_eq)
        begin
            s2_order_next = ORDER_EQUAL;
        end
        else
        begin
            s2_order_next = (mag_gt != na) ? ORDER_GREATER : ORDER_LESS;
        end
    end

    always_comb
    begin
        res         = '0;
        rneg        = 1'b0;
        s2_ovf_next = 1'b0;
        eb          = (mb != '0) && ((s1_type_reg == REQ_SUB) ? !s1_bn_reg : s1_bn_reg);
        case (s1_type_reg)
            REQ_ADD, REQ_SUB:
            begin
                if (na == eb)
                begin
                    res         = sum_w[BCD_W-1:0];
                    rneg        = na;
                    s2_ovf_next = sum_w[BCD_W];
                end
                else if (mag_gt)
                begin
                    res  = ab_w[BCD_W-1:0];
                    rneg = na;
                end
                else
                begin
                    res  = ba_w[BCD_W-1:0];
                    rneg = eb;
                end
            end
            default:
            begin
                res         = '0;
                rneg        = 1'b0;
                s2_ovf_next = 1'b0;
            end
        endcase
        s2_bcd_next = res;
        s2_neg_next = rneg && (res != '0);
        s2_len_next = digit_len(res);
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_type_reg <= req.req_type;
            s1_a_reg    <= req.a_bcd;
            s1_an_reg   <= req.a_neg;
            s1_b_reg    <= req.b_bcd;
            s1_bn_reg   <= req.b_neg;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_bcd_reg   <= s2_bcd_next;
            s2_neg_reg   <= s2_neg_next;
            s2_len_reg   <= s2_len_next;
            s2_ovf_reg   <= s2_ovf_next;
            s2_order_reg <= s2_order_next;
        end
    end

    assign rsp.valid         = s2_valid_reg;
    assign rsp.result_bcd    = s2_bcd_reg;
    assign rsp.result_neg    = s2_neg_reg;
    assign rsp.result_length = s2_len_reg;
    assign rsp.overflow      = s2_ovf_reg;
    assign rsp.order         = s2_order_reg;

    a_zero_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.result_bcd == '0) |-> !rsp.result_neg)
        else $error("zero result marked negative");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.result_length != '0 && rsp.result_length <= LEN_W'(NUM_DIGITS)))
        else $error("result length out of range");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> (s1_valid_reg && $stable(s1_a_reg)
                                        && $stable(s1_b_reg) && $stable(s1_type_reg)))
        else $error("stalled request lost from input register");

    a_equal_sub_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_load && s1_type_reg == REQ_SUB
         && s2_order_next == ORDER_EQUAL) |=> (rsp.result_bcd == '0 && !rsp.overflow))
        else $error("equal operands did not subtract to zero");

endmodule
